// File: sv/price_regime_classifier_top_defines.svh
// ----------------------------------------------------------------------------
// price regime classifier assertion macros
// shared property forms for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef PRICE_REGIME_CLASSIFIER_TOP_DEFINES_SVH
`define PRICE_REGIME_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication
`define PRC_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define PRC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: sv/prc_pkg.sv
// ----------------------------------------------------------------------------
// price regime classifier package
// shared constants, codes and sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package prc_pkg;

   localparam int PRC_MAX_WINDOW = 64;
   localparam int PRC_PRICE_BITS = 24;
   localparam int PRC_SYM_W      = 16;
   localparam int PRC_WINREG_W   = 7;
   localparam int PRC_LIMIT_W    = 19;
   localparam int PRC_RATIO_W    = 20;
   localparam int PRC_FRAC_W     = 16;
   localparam int PRC_SQRT_PAD   = 32;
   localparam int PRC_CSR_IDX_W  = 3;
   localparam int PRC_CSR_DATA_W = 19;

   localparam int PRC_VWIN_RST = 20;
   localparam int PRC_TWIN_RST = 50;
   localparam int PRC_HI_RST   = 1311;
   localparam int PRC_LO_RST   = 655;
   localparam int PRC_TL_RST   = 655;

   // register indexes
   localparam logic [PRC_CSR_IDX_W-1:0] CSR_SYMBOL      = 3'd0;
   localparam logic [PRC_CSR_IDX_W-1:0] CSR_VOL_WINDOW  = 3'd1;
   localparam logic [PRC_CSR_IDX_W-1:0] CSR_TR_WINDOW   = 3'd2;
   localparam logic [PRC_CSR_IDX_W-1:0] CSR_HIGH_LIMIT  = 3'd3;
   localparam logic [PRC_CSR_IDX_W-1:0] CSR_LOW_LIMIT   = 3'd4;
   localparam logic [PRC_CSR_IDX_W-1:0] CSR_TREND_LIMIT = 3'd5;

   // class codes
   localparam logic [1:0] VOL_LOW    = 2'd0;
   localparam logic [1:0] VOL_NORMAL = 2'd1;
   localparam logic [1:0] VOL_HIGH   = 2'd2;
   localparam logic [1:0] TREND_SIDE = 2'd0;
   localparam logic [1:0] TREND_UP   = 2'd1;
   localparam logic [1:0] TREND_DOWN = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD_VOL,
      ST_SUB_VOL,
      ST_MUL_OLD,
      ST_ADD_NEW,
      ST_MUL_NEW,
      ST_VOL_CHK,
      ST_MUL_NQ,
      ST_MUL_SS,
      ST_SQRT,
      ST_DIV,
      ST_MUL_HI,
      ST_MUL_LO,
      ST_RD_TR,
      ST_TR_WAIT,
      ST_MUL_TR,
      ST_DONE
   } prc_state_type;

endpackage

`default_nettype wire

// File: sv/prc_req_if.sv
// ----------------------------------------------------------------------------
// price regime classifier request channel
// valid/ready channel carrying one price tick
// ----------------------------------------------------------------------------
`default_nettype none

interface prc_req_if #(
   parameter int PRICE_BITS = prc_pkg::PRC_PRICE_BITS
);
   logic                            valid;
   logic                            ready;
   logic [prc_pkg::PRC_SYM_W-1:0]   instrument;
   logic [PRICE_BITS-1:0]           price;

   modport source (output valid, output instrument, output price, input ready);
   modport sink   (input valid, input instrument, input price, output ready);
endinterface

`default_nettype wire

// File: sv/prc_rsp_if.sv
// ----------------------------------------------------------------------------
// price regime classifier response channel
// valid/ready channel carrying one classification result
// ----------------------------------------------------------------------------
`default_nettype none

interface prc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              accepted;
   logic [1:0]                        vol_class;
   logic [1:0]                        trend_class;
   logic [prc_pkg::PRC_RATIO_W-1:0]   vol_ratio;
   logic                              regime_changed;

   modport source (output valid, output accepted, output vol_class, output trend_class,
                   output vol_ratio, output regime_changed, input ready);
   modport sink   (input valid, input accepted, input vol_class, input trend_class,
                   input vol_ratio, input regime_changed, output ready);
endinterface

`default_nettype wire

// File: sv/prc_mul.sv
// ----------------------------------------------------------------------------
// price regime classifier shift-add multiplier
// one multiplier bit per cycle, stops early when the multiplier runs out
// ----------------------------------------------------------------------------
`default_nettype none

module prc_mul #(
   parameter int A_W = 8,
   parameter int B_W = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [A_W-1:0]     a,
   input  wire logic [B_W-1:0]     b,
   output logic [A_W+B_W-1:0]      prod,
   output logic                    done
);
   localparam int P_W = A_W + B_W;

   logic [P_W-1:0] acc_ff, acc_in;
   logic [P_W-1:0] a_ff, a_in;
   logic [B_W-1:0] b_ff, b_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = P_W'(a);
         b_in    = b;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[P_W-2:0], 1'b0};
            b_in = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign prod = acc_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// File: sv/prc_sqrt.sv
// ----------------------------------------------------------------------------
// price regime classifier integer square root
// restoring square root, one root bit per cycle, flags a nonzero remainder
// ----------------------------------------------------------------------------
`default_nettype none

module prc_sqrt #(
   parameter int X_W = 96
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [X_W-1:0]   radicand,
   output logic [X_W/2-1:0]      root,
   output logic                  rem_nz,
   output logic                  done
);
   localparam int R_W = X_W / 2;
   localparam int C_W = $clog2(R_W + 1);

   logic [X_W-1:0] rad_ff, rad_in;
   logic [R_W:0]   rem_ff, rem_in;
   logic [R_W-1:0] root_ff, root_in;
   logic [C_W-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [R_W+1:0] rem_t;
   logic [R_W+1:0] trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_t   = {rem_ff[R_W-1:0], rad_ff[X_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = C_W'(R_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[X_W-3:0], 2'b00};
         if (rem_t >= trial) begin
            rem_in  = (R_W+1)'(rem_t - trial);
            root_in = {root_ff[R_W-2:0], 1'b1};
         end else begin
            rem_in  = (R_W+1)'(rem_t);
            root_in = {root_ff[R_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == C_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root   = root_ff;
   assign rem_nz = |rem_ff;
   assign done   = done_ff;

endmodule

`default_nettype wire

// File: sv/prc_div.sv
// ----------------------------------------------------------------------------
// price regime classifier ratio divider
// restoring divide to a saturated fixed-width quotient, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module prc_div #(
   parameter int N_W = 48,
   parameter int S_W = 30
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [N_W-1:0]                   dividend,
   input  wire logic [S_W-1:0]                   divisor,
   output logic [prc_pkg::PRC_RATIO_W-1:0]       quotient,
   output logic                                  done
);
   localparam int Q_W  = prc_pkg::PRC_RATIO_W;
   localparam int H_W  = N_W - Q_W;
   localparam int CW   = (H_W > S_W) ? H_W : S_W;
   localparam int C_W  = $clog2(Q_W + 1);
   localparam logic [Q_W-1:0] SAT = Q_W'(1) << (Q_W - 1);

   logic [S_W-1:0] rem_ff, rem_in;
   logic [S_W-1:0] dvs_ff, dvs_in;
   logic [Q_W-1:0] bits_ff, bits_in;
   logic [Q_W-1:0] q_ff, q_in;
   logic [C_W-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [S_W:0]   t;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      bits_in = bits_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      t       = {rem_ff, bits_ff[Q_W-1]};
      if (start) begin
         dvs_in = divisor;
         if (CW'(dividend[N_W-1:Q_W]) >= CW'(divisor)) begin
            // quotient beyond the field
            q_in    = SAT;
            done_in = 1'b1;
         end else begin
            rem_in  = S_W'(dividend[N_W-1:Q_W]);
            bits_in = dividend[Q_W-1:0];
            q_in    = '0;
            cnt_in  = C_W'(Q_W);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         bits_in = {bits_ff[Q_W-2:0], 1'b0};
         if (t >= {1'b0, dvs_ff}) begin
            rem_in = S_W'(t - {1'b0, dvs_ff});
            q_in   = {q_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_in = S_W'(t);
            q_in   = {q_ff[Q_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == C_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      bits_ff <= bits_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = (q_ff > SAT) ? SAT : q_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// File: sv/price_regime_classifier_top.sv
// ----------------------------------------------------------------------------
// price regime classifier
// volatility (stddev over mean) and trend classification of one price stream
// ----------------------------------------------------------------------------
// usage
// - req_chan takes one tick (instrument, price); a tick is taken when valid
//   and ready are both high at a clock edge
// - rsp_chan returns exactly one result per tick, in order
// - csr_we/csr_index/csr_wdata write the six registers; write only while idle
// - a tick of another instrument goes from idle straight to the done state,
//   skipping the arithmetic, and its result then loads the output register
// - a matched tick runs through one shift-add multiplier, one square root
//   unit and one divider under a sequencer; each multiply steps through
//   the bits of its multiplier and stops when they run out, and the divide
//   finishes at once when it saturates; the time a matched tick takes from
//   acceptance to a valid result and between acceptances is set mostly by
//   the shift-add multiplier
// - req_chan.ready is high only while the sequencer is idle; one tick is in
//   flight at a time
// - the result sits in an output register, so a new tick is taken while the
//   previous result waits; a stalled rsp_chan holds the finished tick in the
//   sequencer until the output register frees up
// - reset clears the history, restores the default register values and sets
//   the classes to normal and sideways with ratio zero
// - writing either window size clears the history but keeps the classes
// ----------------------------------------------------------------------------
`default_nettype none
`include "price_regime_classifier_top_defines.svh"

module price_regime_classifier_top #(
   parameter int MAX_WINDOW = prc_pkg::PRC_MAX_WINDOW,
   parameter int PRICE_BITS = prc_pkg::PRC_PRICE_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   prc_req_if.sink                                   req_chan,
   prc_rsp_if.source                                 rsp_chan,
   input  wire logic                                 csr_we,
   input  wire logic [prc_pkg::PRC_CSR_IDX_W-1:0]    csr_index,
   input  wire logic [prc_pkg::PRC_CSR_DATA_W-1:0]   csr_wdata
);
   // sizes of the history and the running statistics
   localparam int IDX_W = $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = PRICE_BITS + IDX_W;
   localparam int SQ_W  = 2 * PRICE_BITS + IDX_W;
   localparam int LIM_W = prc_pkg::PRC_LIMIT_W;
   localparam int RAT_W = prc_pkg::PRC_RATIO_W;
   localparam int SYM_W = prc_pkg::PRC_SYM_W;
   localparam int WR_W  = prc_pkg::PRC_WINREG_W;
   localparam int FRAC  = prc_pkg::PRC_FRAC_W;
   localparam int PAD   = prc_pkg::PRC_SQRT_PAD;
   // multiplier operand widths
   localparam int MA_W  = SQ_W;
   localparam int MB_W  = (SUM_W > LIM_W) ? SUM_W : LIM_W;
   localparam int P_W   = MA_W + MB_W;
   // n*sumsq - sum^2, then shifted for a Q16 root
   localparam int D_W   = SQ_W + CNT_W;
   localparam int X_W   = D_W + PAD + (D_W % 2);
   localparam int R_W   = X_W / 2;
   localparam int HS_W  = LIM_W + SUM_W;
   localparam int CMP_W = (R_W > HS_W) ? R_W : HS_W;
   localparam int TW_W  = LIM_W + PRICE_BITS;
   localparam int CL_W  = (WR_W > CNT_W) ? WR_W : CNT_W;
   localparam int VW_RST = (prc_pkg::PRC_VWIN_RST > MAX_WINDOW) ?
                           MAX_WINDOW : prc_pkg::PRC_VWIN_RST;
   localparam int TW_RST = (prc_pkg::PRC_TWIN_RST > MAX_WINDOW) ?
                           MAX_WINDOW : prc_pkg::PRC_TWIN_RST;

   // settings
   logic [SYM_W-1:0] sym_ff, sym_in;
   logic [CNT_W-1:0] vwin_ff, vwin_in;
   logic [CNT_W-1:0] twin_ff, twin_in;
   logic [LIM_W-1:0] hi_ff, hi_in;
   logic [LIM_W-1:0] lo_ff, lo_in;
   logic [LIM_W-1:0] tl_ff, tl_in;

   // sequencer and history state
   prc_pkg::prc_state_type state_ff, state_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [CNT_W-1:0]      held_ff, held_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic [1:0]            vol_ff, vol_in;
   logic [1:0]            trend_ff, trend_in;
   logic [RAT_W-1:0]      ratio_ff, ratio_in;

   // per-request working registers
   logic [PRICE_BITS-1:0] price_ff, price_in;
   logic                  used_ff, used_in;
   logic [1:0]            snap_vol_ff, snap_vol_in;
   logic [1:0]            snap_tr_ff, snap_tr_in;
   logic [PRICE_BITS-1:0] old_ff, old_in;
   logic [D_W-1:0]        nq_ff, nq_in;
   logic [R_W-1:0]        root_ff, root_in;
   logic                  rnz_ff, rnz_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_acc_ff, rsp_acc_in;
   logic [1:0]            rsp_vol_ff, rsp_vol_in;
   logic [1:0]            rsp_tr_ff, rsp_tr_in;
   logic [RAT_W-1:0]      rsp_ratio_ff, rsp_ratio_in;
   logic                  rsp_chg_ff, rsp_chg_in;

   // price history
   logic [PRICE_BITS-1:0] hist_mem [MAX_WINDOW];
   logic [PRICE_BITS-1:0] mem_rd_ff;
   logic [IDX_W-1:0]      mem_addr;
   logic                  mem_we;

   // shared units
   logic                  mul_start, mul_done;
   logic [MA_W-1:0]       mul_a;
   logic [MB_W-1:0]       mul_b;
   logic [P_W-1:0]        mul_prod;
   logic                  sq_start, sq_done, sq_rnz;
   logic [X_W-1:0]        sq_rad;
   logic [R_W-1:0]        sq_root;
   logic                  dv_start, dv_done;
   logic [RAT_W-1:0]      dv_q;

   logic                  req_fire;
   logic                  rsp_free;
   logic                  done_fire;
   logic                  mul_wait;
   logic [CNT_W-1:0]      n_cnt;
   logic [D_W-1:0]        dev;
   logic [HS_W-1:0]       lim_prod;
   logic [CL_W-1:0]       win_raw;
   logic [CNT_W-1:0]      win_clamped;

   // oldest slot of a window that ends just before the given slot
   function automatic logic [IDX_W-1:0] back_idx(input logic [IDX_W-1:0] slot,
                                                 input logic [CNT_W-1:0] win);
      logic [IDX_W+1:0] t;
      t = (IDX_W+2)'(slot) + (IDX_W+2)'(MAX_WINDOW) - (IDX_W+2)'(win);
      if (t >= (IDX_W+2)'(MAX_WINDOW)) begin
         t = t - (IDX_W+2)'(MAX_WINDOW);
      end
      return t[IDX_W-1:0];
   endfunction

   prc_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod),
      .done  (mul_done)
   );

   prc_sqrt #(.X_W(X_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .root     (sq_root),
      .rem_nz   (sq_rnz),
      .done     (sq_done)
   );

   prc_div #(.N_W(R_W), .S_W(SUM_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (sq_root),
      .divisor  (sum_ff),
      .quotient (dv_q),
      .done     (dv_done)
   );

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign done_fire = (state_ff == prc_pkg::ST_DONE) && rsp_free;
   assign mul_wait  = (state_ff == prc_pkg::ST_MUL_OLD) || (state_ff == prc_pkg::ST_MUL_NEW) ||
                      (state_ff == prc_pkg::ST_MUL_NQ) || (state_ff == prc_pkg::ST_MUL_SS) ||
                      (state_ff == prc_pkg::ST_MUL_HI) || (state_ff == prc_pkg::ST_MUL_LO) ||
                      (state_ff == prc_pkg::ST_MUL_TR);
   assign n_cnt     = (held_ff < vwin_ff) ? held_ff : vwin_ff;
   assign dev       = nq_ff - D_W'(mul_prod);
   assign lim_prod  = mul_prod[HS_W-1:0];

   // window register: zero reads as one, above the depth as the depth
   assign win_raw = CL_W'(csr_wdata[WR_W-1:0]);
   always_comb begin
      if (win_raw == '0) begin
         win_clamped = CNT_W'(1);
      end else if (win_raw > CL_W'(MAX_WINDOW)) begin
         win_clamped = CNT_W'(MAX_WINDOW);
      end else begin
         win_clamped = win_raw[CNT_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sym_in       = sym_ff;
      vwin_in      = vwin_ff;
      twin_in      = twin_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      tl_in        = tl_ff;
      slot_in      = slot_ff;
      held_in      = held_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      vol_in       = vol_ff;
      trend_in     = trend_ff;
      ratio_in     = ratio_ff;
      price_in     = price_ff;
      used_in      = used_ff;
      snap_vol_in  = snap_vol_ff;
      snap_tr_in   = snap_tr_ff;
      old_in       = old_ff;
      nq_in        = nq_ff;
      root_in      = root_ff;
      rnz_in       = rnz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_acc_in   = rsp_acc_ff;
      rsp_vol_in   = rsp_vol_ff;
      rsp_tr_in    = rsp_tr_ff;
      rsp_ratio_in = rsp_ratio_ff;
      rsp_chg_in   = rsp_chg_ff;
      mem_addr     = slot_ff;
      mem_we       = 1'b0;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      sq_start     = 1'b0;
      sq_rad       = X_W'({dev, PAD'(0)});
      dv_start     = 1'b0;

      case (state_ff)
         prc_pkg::ST_IDLE: begin
            if (req_fire) begin
               price_in    = req_chan.price;
               used_in     = (req_chan.instrument == sym_ff);
               snap_vol_in = vol_ff;
               snap_tr_in  = trend_ff;
               state_in    = (req_chan.instrument == sym_ff) ?
                             prc_pkg::ST_RD_VOL : prc_pkg::ST_DONE;
            end
         end
         prc_pkg::ST_RD_VOL: begin
            // price leaving the volatility window, read before the overwrite
            mem_addr = back_idx(slot_ff, vwin_ff);
            state_in = prc_pkg::ST_SUB_VOL;
         end
         prc_pkg::ST_SUB_VOL: begin
            if (held_ff >= vwin_ff) begin
               sum_in    = sum_ff - SUM_W'(mem_rd_ff);
               mul_start = 1'b1;
               mul_a     = MA_W'(mem_rd_ff);
               mul_b     = MB_W'(mem_rd_ff);
               state_in  = prc_pkg::ST_MUL_OLD;
            end else begin
               state_in = prc_pkg::ST_ADD_NEW;
            end
         end
         prc_pkg::ST_MUL_OLD: begin
            if (mul_done) begin
               sq_in    = sq_ff - SQ_W'(mul_prod);
               state_in = prc_pkg::ST_ADD_NEW;
            end
         end
         prc_pkg::ST_ADD_NEW: begin
            mem_addr  = slot_ff;
            mem_we    = 1'b1;
            sum_in    = sum_ff + SUM_W'(price_ff);
            slot_in   = (slot_ff == IDX_W'(MAX_WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            if (held_ff < CNT_W'(MAX_WINDOW)) begin
               held_in = held_ff + 1'b1;
            end
            mul_start = 1'b1;
            mul_a     = MA_W'(price_ff);
            mul_b     = MB_W'(price_ff);
            state_in  = prc_pkg::ST_MUL_NEW;
         end
         prc_pkg::ST_MUL_NEW: begin
            if (mul_done) begin
               sq_in    = sq_ff + SQ_W'(mul_prod);
               state_in = prc_pkg::ST_VOL_CHK;
            end
         end
         prc_pkg::ST_VOL_CHK: begin
            if (n_cnt >= CNT_W'(2)) begin
               if (sum_ff == '0) begin
                  // flat zero window
                  ratio_in = '0;
                  vol_in   = prc_pkg::VOL_NORMAL;
                  state_in = prc_pkg::ST_RD_TR;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = sq_ff;
                  mul_b     = MB_W'(n_cnt);
                  state_in  = prc_pkg::ST_MUL_NQ;
               end
            end else begin
               state_in = prc_pkg::ST_RD_TR;
            end
         end
         prc_pkg::ST_MUL_NQ: begin
            if (mul_done) begin
               nq_in     = D_W'(mul_prod);
               mul_start = 1'b1;
               mul_a     = MA_W'(sum_ff);
               mul_b     = MB_W'(sum_ff);
               state_in  = prc_pkg::ST_MUL_SS;
            end
         end
         prc_pkg::ST_MUL_SS: begin
            if (mul_done) begin
               sq_start = 1'b1;
               state_in = prc_pkg::ST_SQRT;
            end
         end
         prc_pkg::ST_SQRT: begin
            if (sq_done) begin
               root_in  = sq_root;
               rnz_in   = sq_rnz;
               dv_start = 1'b1;
               state_in = prc_pkg::ST_DIV;
            end
         end
         prc_pkg::ST_DIV: begin
            if (dv_done) begin
               ratio_in  = dv_q;
               mul_start = 1'b1;
               mul_a     = MA_W'(sum_ff);
               mul_b     = MB_W'(hi_ff);
               state_in  = prc_pkg::ST_MUL_HI;
            end
         end
         prc_pkg::ST_MUL_HI: begin
            if (mul_done) begin
               // exact test of x > (hi*sum)^2 through the root and remainder
               if ((CMP_W'(root_ff) > CMP_W'(lim_prod)) ||
                   ((CMP_W'(root_ff) == CMP_W'(lim_prod)) && rnz_ff)) begin
                  vol_in   = prc_pkg::VOL_HIGH;
                  state_in = prc_pkg::ST_RD_TR;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = MA_W'(sum_ff);
                  mul_b     = MB_W'(lo_ff);
                  state_in  = prc_pkg::ST_MUL_LO;
               end
            end
         end
         prc_pkg::ST_MUL_LO: begin
            if (mul_done) begin
               vol_in   = (CMP_W'(root_ff) < CMP_W'(lim_prod)) ?
                          prc_pkg::VOL_LOW : prc_pkg::VOL_NORMAL;
               state_in = prc_pkg::ST_RD_TR;
            end
         end
         prc_pkg::ST_RD_TR: begin
            // slot already advanced past the newest price
            mem_addr = back_idx(slot_ff, twin_ff);
            state_in = (held_ff >= twin_ff) ? prc_pkg::ST_TR_WAIT : prc_pkg::ST_DONE;
         end
         prc_pkg::ST_TR_WAIT: begin
            if (mem_rd_ff == '0) begin
               trend_in = (price_ff != '0) ? prc_pkg::TREND_UP : prc_pkg::TREND_SIDE;
               state_in = prc_pkg::ST_DONE;
            end else begin
               old_in    = mem_rd_ff;
               mul_start = 1'b1;
               mul_a     = MA_W'(mem_rd_ff);
               mul_b     = MB_W'(tl_ff);
               state_in  = prc_pkg::ST_MUL_TR;
            end
         end
         prc_pkg::ST_MUL_TR: begin
            if (mul_done) begin
               if ((price_ff > old_ff) &&
                   (TW_W'({price_ff - old_ff, FRAC'(0)}) > TW_W'(mul_prod))) begin
                  trend_in = prc_pkg::TREND_UP;
               end else if ((old_ff > price_ff) &&
                   (TW_W'({old_ff - price_ff, FRAC'(0)}) > TW_W'(mul_prod))) begin
                  trend_in = prc_pkg::TREND_DOWN;
               end else begin
                  trend_in = prc_pkg::TREND_SIDE;
               end
               state_in = prc_pkg::ST_DONE;
            end
         end
         prc_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = used_ff;
               rsp_vol_in   = vol_ff;
               rsp_tr_in    = trend_ff;
               rsp_ratio_in = ratio_ff;
               rsp_chg_in   = used_ff && ((vol_ff != snap_vol_ff) ||
                                          (trend_ff != snap_tr_ff));
               state_in     = prc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = prc_pkg::ST_IDLE;
         end
      endcase

      // register writes; the user must write only while idle, the block itself does not enforce it
      if (csr_we) begin
         case (csr_index)
            prc_pkg::CSR_SYMBOL: begin
               sym_in = csr_wdata[SYM_W-1:0];
            end
            prc_pkg::CSR_VOL_WINDOW: begin
               vwin_in = win_clamped;
               slot_in = '0;
               held_in = '0;
               sum_in  = '0;
               sq_in   = '0;
            end
            prc_pkg::CSR_TR_WINDOW: begin
               twin_in = win_clamped;
               slot_in = '0;
               held_in = '0;
               sum_in  = '0;
               sq_in   = '0;
            end
            prc_pkg::CSR_HIGH_LIMIT: begin
               hi_in = csr_wdata[LIM_W-1:0];
            end
            prc_pkg::CSR_LOW_LIMIT: begin
               lo_in = csr_wdata[LIM_W-1:0];
            end
            prc_pkg::CSR_TREND_LIMIT: begin
               tl_in = csr_wdata[LIM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prc_pkg::ST_IDLE;
         sym_ff       <= '0;
         vwin_ff      <= CNT_W'(VW_RST);
         twin_ff      <= CNT_W'(TW_RST);
         hi_ff        <= LIM_W'(prc_pkg::PRC_HI_RST);
         lo_ff        <= LIM_W'(prc_pkg::PRC_LO_RST);
         tl_ff        <= LIM_W'(prc_pkg::PRC_TL_RST);
         slot_ff      <= '0;
         held_ff      <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         vol_ff       <= prc_pkg::VOL_NORMAL;
         trend_ff     <= prc_pkg::TREND_SIDE;
         ratio_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sym_ff       <= sym_in;
         vwin_ff      <= vwin_in;
         twin_ff      <= twin_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
         tl_ff        <= tl_in;
         slot_ff      <= slot_in;
         held_ff      <= held_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         vol_ff       <= vol_in;
         trend_ff     <= trend_in;
         ratio_ff     <= ratio_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      price_ff     <= price_in;
      used_ff      <= used_in;
      snap_vol_ff  <= snap_vol_in;
      snap_tr_ff   <= snap_tr_in;
      old_ff       <= old_in;
      nq_ff        <= nq_in;
      root_ff      <= root_in;
      rnz_ff       <= rnz_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_vol_ff   <= rsp_vol_in;
      rsp_tr_ff    <= rsp_tr_in;
      rsp_ratio_ff <= rsp_ratio_in;
      rsp_chg_ff   <= rsp_chg_in;
   end

   // history ring, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_addr] <= price_ff;
      end
      mem_rd_ff <= hist_mem[mem_addr];
   end

   assign req_chan.ready          = (state_ff == prc_pkg::ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.accepted       = rsp_acc_ff;
   assign rsp_chan.vol_class      = rsp_vol_ff;
   assign rsp_chan.trend_class    = rsp_tr_ff;
   assign rsp_chan.vol_ratio      = rsp_ratio_ff;
   assign rsp_chan.regime_changed = rsp_chg_ff;

   // one request in flight at a time
   `PRC_ASSERT_NEXT(a_one_in_flight, clock, reset, req_fire, !req_chan.ready, "taken while busy")
   // fill count never passes the ring depth
   `PRC_ASSERT_NOW(a_held_bound, clock, reset, 1'b1, held_ff <= CNT_W'(MAX_WINDOW), "fill overflow")
   // a multiplier result only arrives where the sequencer waits for one
   `PRC_ASSERT_NOW(a_mul_done_state, clock, reset, mul_done, mul_wait, "stray multiplier result")
   // a finished request lands in the output register
   `PRC_ASSERT_NEXT(a_done_loads, clock, reset, done_fire, rsp_valid_ff, "result dropped")

endmodule

`default_nettype wire
